### rtl/core/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants for the decimal text converter
// Field widths, ASCII codes, sequencer states and the BCD add-3 helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

  // Field widths
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CharW   = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW    = NumDigits * DigitW;
  localparam int unsigned StepCntW = $clog2(ValueW);
  localparam int unsigned LeftW   = $clog2(NumDigits + 1);

  // ASCII codes
  localparam logic [CharW-1:0] AsciiMinus = 8'd45;
  localparam logic [CharW-1:0] AsciiZero  = 8'd48;
  localparam logic [CharW-1:0] AsciiNine  = 8'd57;

  // Output sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_SIGN,
    ST_DIGITS
  } state_e;

  // Add 3 to every BCD digit that is 5 or more, ahead of a left shift
  function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] bcd);
    logic [BcdW-1:0] res;
    res = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[i*DigitW +: DigitW] >= 4'd5) begin
        res[i*DigitW +: DigitW] = bcd[i*DigitW +: DigitW] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/sitda_bcd_conv.sv
// ----------------------------------------------------------------------------
// sitda_bcd_conv: iterative binary to BCD converter
// Shift-and-add-3 over one shared adjust unit, one input bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitda_bcd_conv
  import sitda_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ValueW-1:0] mag_i,
  output logic                   done_o,
  output logic [BcdW-1:0]        bcd_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [ValueW-1:0]   bin_q, bin_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic [BcdW-1:0]     adj;

  // Adjust digits, then shift the next binary bit in
  always_comb begin
    adj    = bcd_adjust(bcd_q);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = mag_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[ValueW-1]};
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepCntW'(ValueW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

### rtl/core/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Streams the decimal text of each request, sign first, one char per beat.
// ----------------------------------------------------------------------------
// One request carries a signed 32-bit value; the block answers with its
// decimal text, most significant digit first, a leading '-' for negative
// values, no leading zeros, and tlast on the final character. The most
// negative value prints in full. With output_enable clear a request is taken
// and produces no text, and the block is ready again the next cycle. The
// block takes one request at a time: the shift-and-add-3 BCD unit converts
// the magnitude and hands its digits over, then leading zeros are dropped one
// per cycle and the sign and digits leave one per cycle while the character
// side does not stall. The block is ready for the next request as soon as the
// last character sits in the output register; a stall on the character side
// delays it.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,     // output_enable
  // Request stream
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [ValueW-1:0] s_axis_tdata_i,  // [31:0] value
  // Character stream
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [CharW-1:0]       m_axis_tdata_o,  // [7:0] character
  output logic                   m_axis_tlast_o   // last
);

  state_e            state_q, state_d;
  logic              enable_q;
  logic              neg_q, neg_d;
  logic [BcdW-1:0]   digits_q, digits_d;
  logic [LeftW-1:0]  left_q, left_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              out_last_q, out_last_d;
  logic              conv_start;
  logic              conv_done;
  logic [BcdW-1:0]   conv_bcd;
  logic [ValueW-1:0] mag;
  logic              in_fire;
  logic              slot_free;
  logic [DigitW-1:0] top_digit;

  // Magnitude as unsigned, correct for the most negative value
  assign mag = s_axis_tdata_i[ValueW-1] ? (ValueW'(0) - s_axis_tdata_i) : s_axis_tdata_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign top_digit = digits_q[BcdW-1 -: DigitW];

  sitda_bcd_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .mag_i   (mag),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  // Sequencer: convert, drop leading zeros, emit sign and digits
  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    digits_d    = digits_q;
    left_d      = left_q;
    conv_start  = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && enable_q) begin
          neg_d      = s_axis_tdata_i[ValueW-1];
          conv_start = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          digits_d = conv_bcd;
          left_d   = LeftW'(NumDigits);
          state_d  = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (top_digit == '0 && left_q > LeftW'(1)) begin
          digits_d = {digits_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          left_d   = left_q - 1'b1;
        end else begin
          state_d = neg_q ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = AsciiMinus;
          out_last_d  = 1'b0;
          state_d     = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = AsciiZero + CharW'(top_digit);
          out_last_d  = (left_q == LeftW'(1));
          digits_d    = {digits_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          left_d      = left_q - 1'b1;
          if (left_q == LeftW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      enable_q    <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    digits_q   <= digits_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

### rtl/core/sitda_checker.sv
// ----------------------------------------------------------------------------
// sitda_checker: port-level checks for the decimal text converter
// Watches the character stream and the request handshake over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitda_checker
  import sitda_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tready_o,
  input wire logic              m_axis_tvalid_o,
  input wire logic              m_axis_tready_i,
  input wire logic [CharW-1:0]  m_axis_tdata_o,
  input wire logic              m_axis_tlast_o
);

  // Hold a stalled character
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled character changed");

  // Emit only a minus sign or a decimal digit
  a_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o == AsciiMinus) ||
      ((m_axis_tdata_o >= AsciiZero) && (m_axis_tdata_o <= AsciiNine)))
    else $error("character outside sign and digits");

  // Never close a run on the sign
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o == AsciiMinus) |-> !m_axis_tlast_o)
    else $error("run ends on minus sign");

  // Take no request while a run is still open
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("request taken mid-run");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
